FILE: rtl/core/pem_pkg.sv
// shared types and constants for the prewitt edge magnitude block
package pem_pkg;

    // input request payload
    typedef struct packed {
        logic        cmd;
        logic [31:0] pixel_word;
    } t_in_item;

    // output request payload
    typedef struct packed {
        logic [7:0]  edge_value;
        logic [31:0] packed_out;
        logic        frame_last;
    } t_out_item;

    // item commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;
    localparam int unsigned CFG_DATA_W = 16;

    // register reset values
    localparam int unsigned WIDTH_RESET  = 640;
    localparam int unsigned HEIGHT_RESET = 480;

    // luma weights, q0.16
    localparam logic [15:0] W_RED   = 16'd13933;
    localparam logic [15:0] W_GREEN = 16'd46871;
    localparam logic [15:0] W_BLUE  = 16'd4732;

    // sigmoid output levels by integer magnitude
    localparam logic [7:0] SIG_M0  = 8'd127;
    localparam logic [7:0] SIG_M1  = 8'd186;
    localparam logic [7:0] SIG_M2  = 8'd224;
    localparam logic [7:0] SIG_M3  = 8'd242;
    localparam logic [7:0] SIG_M4  = 8'd250;
    localparam logic [7:0] SIG_M5  = 8'd253;
    localparam logic [7:0] SIG_MID = 8'd254;
    localparam logic [7:0] SIG_TOP = 8'd255;
    localparam int unsigned SIG_TOP_M = 18;

    localparam logic [7:0] ALPHA_FULL = 8'hFF;

endpackage

FILE: rtl/core/pem_edge_map.sv
// gradient to sigmoid edge level: squares, sum, threshold compare
module pem_edge_map #(
    parameter int unsigned LUMA_FRAC_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [LUMA_FRAC_BITS+10:0] i_gx,
    input  logic signed [LUMA_FRAC_BITS+10:0] i_gy,
    output logic                          o_done,
    output logic [7:0]                    o_edge
);
    import pem_pkg::*;

    localparam int unsigned GW = LUMA_FRAC_BITS + 11;
    localparam int unsigned QW = 2 * GW;
    localparam int unsigned SW = QW + 1;
    localparam int unsigned F2 = 2 * LUMA_FRAC_BITS;

    logic [2:0]    r_vld;
    logic [QW-1:0] r_gx2;
    logic [QW-1:0] r_gy2;
    logic [SW-1:0] r_s;
    logic [7:0]    r_edge;
    logic [7:0]    edge_sel;

    // magnitude m >= k exactly when s >= (k << frac)^2
    function automatic logic [SW-1:0] thr(input int unsigned k);
        thr = SW'(k * k) << F2;
    endfunction

    always_comb begin
        if (r_s >= thr(SIG_TOP_M)) begin
            edge_sel = SIG_TOP;
        end else if (r_s >= thr(6)) begin
            edge_sel = SIG_MID;
        end else if (r_s >= thr(5)) begin
            edge_sel = SIG_M5;
        end else if (r_s >= thr(4)) begin
            edge_sel = SIG_M4;
        end else if (r_s >= thr(3)) begin
            edge_sel = SIG_M3;
        end else if (r_s >= thr(2)) begin
            edge_sel = SIG_M2;
        end else if (r_s >= thr(1)) begin
            edge_sel = SIG_M1;
        end else begin
            edge_sel = SIG_M0;
        end
    end

    // three stage pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_start};
        end
        r_gx2  <= QW'(i_gx * i_gx);
        r_gy2  <= QW'(i_gy * i_gy);
        r_s    <= SW'(r_gx2) + SW'(r_gy2);
        r_edge <= edge_sel;
    end

    assign o_done = r_vld[2];
    assign o_edge = r_edge;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##3 o_done) else $error("edge map latency broken");
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_edge >= SIG_M0) else $error("edge level below floor");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("edge map done held");
`endif

endmodule

FILE: rtl/core/prewitt_edge_magnitude_sigmoid_top.sv
// top level: luma conversion, ring line store, window sequencer and output register
// A pixel or drain request is taken when the block is idle. A request that gives
// no result only passes the take-in and luma states. A request that gives a result
// is taken in, converted to luma and, for a pixel, written to the store; the nine
// window taps are read through the single read port of the line store, the sums
// pass the squaring and threshold pipe and the result loads the output register,
// which lets the next request in while a result waits. Configuration writes are
// taken only while idle. The result for pixel p comes out with input pixel
// p+width+1; drain requests flush the tail of a frame. The line store holds
// 2*MAX_WIDTH+3 luma entries and needs no clearing pass.
module prewitt_edge_magnitude_sigmoid_top #(
    parameter int unsigned MAX_WIDTH      = 2048,
    parameter int unsigned LUMA_FRAC_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  pem_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output pem_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pem_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pem_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pem_pkg::*;

    localparam int unsigned DEPTH = 2 * MAX_WIDTH + 3;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned CW    = $clog2(MAX_WIDTH);
    localparam int unsigned LW    = 8 + LUMA_FRAC_BITS;
    localparam int unsigned GW    = LUMA_FRAC_BITS + 11;
    localparam int unsigned OW    = AW + 2;
    localparam int unsigned WRESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

    typedef enum logic [2:0] {S_IDLE, S_LUMA, S_READ, S_MAG, S_OUT} t_state;

    t_state              r_state;
    logic                r_cmd;
    logic [31:0]         r_pix;
    logic [WW-1:0]       r_width;
    logic [15:0]         r_height;
    logic [CW-1:0]       r_in_col;
    logic [15:0]         r_in_row;
    logic [CW-1:0]       r_out_col;
    logic [15:0]         r_out_row;
    logic [AW-1:0]       r_wr_addr;
    logic [AW-1:0]       r_p_addr;
    logic [3:0]          r_tap;
    logic [1:0]          r_rd_k;
    logic [1:0]          r_rd_l;
    logic                r_rd_vld;
    logic [LW-1:0]       r_rd_data;
    logic signed [GW-1:0] r_gx;
    logic signed [GW-1:0] r_gy;
    logic                r_map_start;
    logic [7:0]          r_edge;
    logic                r_out_valid;
    t_out_item           r_out_data;
    logic [LW-1:0]       mem [DEPTH];

    logic [23:0]         luma_sum;
    logic [LW-1:0]       luma;
    logic                is_pixel;
    logic                primed;
    logic                mem_we;
    logic [1:0]          tap_k;
    logic [1:0]          tap_l;
    logic                top_edge;
    logic                bot_edge;
    logic                left_edge;
    logic                right_edge;
    logic signed [OW-1:0] off;
    logic signed [OW-1:0] addr_sum;
    logic [AW-1:0]       rd_addr;
    logic                map_done;
    logic [7:0]          map_edge;
    logic                frame_end;
    logic [WW-1:0]       cfg_w;
    logic [15:0]         cfg_h;
    logic signed [GW-1:0] tap_val;
    logic                out_load;

    // luma from rgb, truncating
    assign luma_sum = 24'(r_pix[7:0] * W_RED) + 24'(r_pix[15:8] * W_GREEN)
                    + 24'(r_pix[23:16] * W_BLUE);
    assign luma     = LW'(luma_sum >> (16 - LUMA_FRAC_BITS));

    assign is_pixel = (r_cmd == CMD_PIXEL) && (r_in_row < r_height);
    assign primed   = (r_in_row >= 16'd2) || ((r_in_row == 16'd1) && (r_in_col != '0));
    assign mem_we   = (r_state == S_LUMA) && is_pixel;

    // tap position in the window
    always_comb begin
        case (r_tap)
            4'd0: begin tap_k = 2'd0; tap_l = 2'd0; end
            4'd1: begin tap_k = 2'd0; tap_l = 2'd1; end
            4'd2: begin tap_k = 2'd0; tap_l = 2'd2; end
            4'd3: begin tap_k = 2'd1; tap_l = 2'd0; end
            4'd4: begin tap_k = 2'd1; tap_l = 2'd1; end
            4'd5: begin tap_k = 2'd1; tap_l = 2'd2; end
            4'd6: begin tap_k = 2'd2; tap_l = 2'd0; end
            4'd7: begin tap_k = 2'd2; tap_l = 2'd1; end
            default: begin tap_k = 2'd2; tap_l = 2'd2; end
        endcase
    end

    // clamp-to-edge tap address in the ring
    assign top_edge   = (r_out_row == 16'd0);
    assign bot_edge   = ({1'b0, r_out_row} + 17'd1) == {1'b0, r_height};
    assign left_edge  = (r_out_col == '0);
    assign right_edge = (WW'(r_out_col) + WW'(1)) == r_width;

    always_comb begin
        off = '0;
        if (tap_k == 2'd0 && !top_edge) begin
            off = off - OW'(r_width);
        end else if (tap_k == 2'd2 && !bot_edge) begin
            off = off + OW'(r_width);
        end
        if (tap_l == 2'd0 && !left_edge) begin
            off = off - OW'(1);
        end else if (tap_l == 2'd2 && !right_edge) begin
            off = off + OW'(1);
        end
        addr_sum = OW'(r_p_addr) + off;
        if (addr_sum < 0) begin
            addr_sum = addr_sum + OW'(DEPTH);
        end else if (addr_sum >= OW'(DEPTH)) begin
            addr_sum = addr_sum - OW'(DEPTH);
        end
        rd_addr = AW'(addr_sum);
    end

    // line store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wr_addr] <= luma;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign tap_val   = GW'(r_rd_data);
    assign frame_end = bot_edge && right_edge;

    // repaired config values
    always_comb begin
        cfg_w = (i_cfg_data[11:0] == 12'd0) ? WW'(1) :
                ({4'd0, i_cfg_data[11:0]} > 16'(MAX_WIDTH)) ? WW'(MAX_WIDTH) :
                WW'(i_cfg_data[11:0]);
        cfg_h = (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
    end

    // output register takes a result when it is free or being emptied
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_width     <= WW'(WRESET);
            r_height    <= 16'(HEIGHT_RESET);
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_wr_addr   <= '0;
            r_p_addr    <= '0;
            r_tap       <= '0;
            r_rd_vld    <= 1'b0;
            r_map_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_map_start <= (r_state == S_READ) && !(r_tap < 4'd9);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // a width or height config write restarts the frame
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_IMAGE_WIDTH || i_cfg_index == CFG_IMAGE_HEIGHT) begin
                    if (i_cfg_index == CFG_IMAGE_WIDTH) begin
                        r_width <= cfg_w;
                    end else begin
                        r_height <= cfg_h;
                    end
                    r_in_col  <= '0;
                    r_in_row  <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                    r_wr_addr <= '0;
                    r_p_addr  <= '0;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        r_cmd   <= i_in_data.cmd;
                        r_pix   <= i_in_data.pixel_word;
                        r_state <= S_LUMA;
                    end
                end
                S_LUMA: begin
                    r_tap <= '0;
                    r_gx  <= '0;
                    r_gy  <= '0;
                    if (is_pixel) begin
                        r_wr_addr <= (r_wr_addr == AW'(DEPTH - 1)) ? '0 : r_wr_addr + AW'(1);
                        if ((WW'(r_in_col) + WW'(1)) == r_width) begin
                            r_in_col <= '0;
                            r_in_row <= r_in_row + 16'd1;
                        end else begin
                            r_in_col <= r_in_col + CW'(1);
                        end
                        r_state <= primed ? S_READ : S_IDLE;
                    end else begin
                        r_state <= (r_in_row >= r_height) ? S_READ : S_IDLE;
                    end
                end
                S_READ: begin
                    r_rd_vld <= (r_tap < 4'd9);
                    r_rd_k   <= tap_k;
                    r_rd_l   <= tap_l;
                    if (r_tap < 4'd9) begin
                        r_tap <= r_tap + 4'd1;
                    end else begin
                        r_state <= S_MAG;
                    end
                    if (r_rd_vld) begin
                        if (r_rd_l == 2'd0) begin
                            r_gx <= r_gx + tap_val;
                        end else if (r_rd_l == 2'd2) begin
                            r_gx <= r_gx - tap_val;
                        end
                        if (r_rd_k == 2'd0) begin
                            r_gy <= r_gy + tap_val;
                        end else if (r_rd_k == 2'd2) begin
                            r_gy <= r_gy - tap_val;
                        end
                    end
                end
                S_MAG: begin
                    r_rd_vld <= 1'b0;
                    if (map_done) begin
                        r_edge  <= map_edge;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out_data.edge_value <= r_edge;
                        r_out_data.packed_out <= {r_edge, r_edge, r_edge, ALPHA_FULL};
                        r_out_data.frame_last <= frame_end;
                        r_state               <= S_IDLE;
                        if (frame_end) begin
                            r_in_col  <= '0;
                            r_in_row  <= '0;
                            r_out_col <= '0;
                            r_out_row <= '0;
                            r_wr_addr <= '0;
                            r_p_addr  <= '0;
                        end else begin
                            r_p_addr <= (r_p_addr == AW'(DEPTH - 1)) ? '0 : r_p_addr + AW'(1);
                            if (right_edge) begin
                                r_out_col <= '0;
                                r_out_row <= r_out_row + 16'd1;
                            end else begin
                                r_out_col <= r_out_col + CW'(1);
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    pem_edge_map #(
        .LUMA_FRAC_BITS(LUMA_FRAC_BITS)
    ) u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_map_start),
        .i_gx    (r_gx),
        .i_gy    (r_gy),
        .o_done  (map_done),
        .o_edge  (map_edge)
    );

    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_row <= r_height) else $error("input row past frame");
    a_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_addr < AW'(DEPTH)) && (r_p_addr < AW'(DEPTH)) && (rd_addr < AW'(DEPTH)))
        else $error("ring address out of range");
    a_tap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> r_tap <= 4'd9) else $error("tap counter overrun");
    a_out_follows_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT) else $error("stray result");
`endif

endmodule
